// ----- hw/rtl/dvrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

	localparam int unsigned NODES_DEF     = 16;
	localparam int unsigned COST_BITS_DEF = 16;
	localparam int unsigned MAX_RESULTS   = 16;
	localparam int unsigned CNT_BITS      = $clog2(MAX_RESULTS);

	localparam int unsigned ID_BITS       = 4;
	localparam int unsigned SIG_BITS      = 8;
	localparam int unsigned ADV_BITS      = 16;
	localparam int unsigned OUT_COST_BITS = 16;
	localparam int unsigned CFG_BITS      = 16;
	localparam int unsigned IDX_BITS      = 2;
	localparam int unsigned IN_BITS       = 32;
	localparam int unsigned OUT_BITS      = 32;

	localparam logic signed [SIG_BITS-1:0] SIG_THR_RESET    = -8'sd90;
	localparam logic [ADV_BITS-1:0]        COST_LIMIT_RESET = 16'd16;

	// operation of an input item, and kind of a result item
	typedef enum logic [1:0] {
		OP_LINK  = 2'd0,
		OP_VEC   = 2'd1,
		OP_QUERY = 2'd2,
		OP_DUMP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_OWN_ID     = 2'd0,
		REG_SIG_THR    = 2'd1,
		REG_COST_LIMIT = 2'd2,
		REG_ROUTE_EN   = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_ACCEPT,
		ACT_LINK,
		ACT_TEAR,
		ACT_W1,
		ACT_W2,
		ACT_VCLR,
		ACT_QUERY,
		ACT_DUMP,
		ACT_FIN,
		ACT_EMIT
	} act_t;

	typedef enum logic [1:0] {
		RS_PEER,
		RS_DEST,
		RS_WALK
	} rsel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LINK_RD,
		ST_LINK_EX,
		ST_TEAR_RD,
		ST_TEAR_EX,
		ST_VEC_RD,
		ST_VEC_CHK,
		ST_W1_RD,
		ST_W1_EX,
		ST_W2_RD,
		ST_W2_EX,
		ST_VCLR,
		ST_QRY_RD,
		ST_QRY_EX,
		ST_DUMP_RD,
		ST_DUMP_EX,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		act_t  act;
		rsel_t rsel;
	} dvrt_cmd_t;

	typedef struct packed {
		logic out_free;
		logic tear;
		logic direct;
		logic hit;
		logic pend_v;
	} dvrt_sts_t;

endpackage

// ----- hw/rtl/dvrt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_datapath
// Route storage, vector buffer, configuration registers and result register.
// ----------------------------------------------------------------------------
module dvrt_datapath #(
	parameter int unsigned NODES     = dvrt_pkg::NODES_DEF,
	parameter int unsigned COST_BITS = dvrt_pkg::COST_BITS_DEF,
	parameter int unsigned IW        = $clog2(NODES)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dvrt_pkg::dvrt_cmd_t                cmd,
	input  logic [IW-1:0]                      ix,
	input  logic [IW-1:0]                      walk_addr,
	output dvrt_pkg::dvrt_sts_t                sts,
	input  logic [dvrt_pkg::IN_BITS-1:0]       s_tdata,
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dvrt_pkg::OUT_BITS-1:0]      m_tdata,
	output logic [1:0]                         m_tuser,
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic [dvrt_pkg::IDX_BITS-1:0]      cfg_index,
	input  logic [dvrt_pkg::CFG_BITS-1:0]      cfg_data
);
	import dvrt_pkg::*;

	localparam int unsigned SW = (COST_BITS > ADV_BITS) ? COST_BITS : ADV_BITS;
	localparam int unsigned DW = (COST_BITS + 1 > OUT_COST_BITS + 1) ?
		COST_BITS + 1 : OUT_COST_BITS + 1;
	localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};
	localparam logic [COST_BITS-1:0] COST_ONE = COST_BITS'(1);

	// configuration
	logic [ID_BITS-1:0]        own_q;
	logic signed [SIG_BITS-1:0] thr_q;
	logic [ADV_BITS-1:0]       limit_q;
	logic                      ren_q;

	// latched item
	op_t                       op_q;
	logic [ID_BITS-1:0]        peer_q;
	logic signed [SIG_BITS-1:0] sig_q;
	logic [ID_BITS-1:0]        dest_q;

	logic [NODES-1:0]          valid_q;
	logic [NODES-1:0]          seen_q;

	logic [ID_BITS-1:0]        nh_mem   [NODES];
	logic [COST_BITS-1:0]      cost_mem [NODES];
	logic [ADV_BITS-1:0]       vc_mem   [NODES];
	logic [ID_BITS-1:0]        nh_rd;
	logic [COST_BITS-1:0]      cost_rd;
	logic [ADV_BITS-1:0]       vc_rd;

	logic                      mod_q, newc_q, newr_q, hv_q;
	logic [ID_BITS-1:0]        hop_q;
	logic                      pend_v_q;
	logic [ID_BITS-1:0]        pend_d_q;
	logic [OUT_COST_BITS-1:0]  pend_cost_q;

	logic [IW-1:0]             raddr, peer_ix, dest_ix, in_ix;
	logic [ID_BITS-1:0]        in_dest;
	logic                      peer_rng, dest_rng, in_rng;
	logic                      link_ok, sig_up, direct, install, tear;
	logic [SW-1:0]             v_ext, c_ext;
	logic [COST_BITS-1:0]      v_sat;
	logic                      w1_match, w1_raise, w2_ok, w2_better;
	logic [DW-1:0]             c_inc;
	logic [OUT_COST_BITS-1:0]  dump_cost;
	logic                      out_free, dump_take, ld_out;
	logic [OUT_BITS-1:0]       ld_data;
	logic                      ld_last;
	logic                      nh_we, cost_we;
	logic [IW-1:0]             wa;
	logic [COST_BITS-1:0]      cost_wd;

	assign peer_ix  = IW'(peer_q);
	assign dest_ix  = IW'(dest_q);
	assign in_dest  = s_tdata[15:12];
	assign in_ix    = IW'(in_dest);
	assign peer_rng = 9'(peer_q) < 9'(NODES);
	assign dest_rng = 9'(dest_q) < 9'(NODES);
	assign in_rng   = 9'(in_dest) < 9'(NODES);

	always_comb begin
		case (cmd.rsel)
			RS_PEER: raddr = peer_ix;
			RS_DEST: raddr = dest_ix;
			default: raddr = walk_addr;
		endcase
	end

	assign link_ok = peer_rng && (peer_q != own_q);
	assign sig_up  = sig_q > thr_q;
	assign direct  = peer_rng && valid_q[peer_ix] && (nh_rd == peer_q);
	assign install = link_ok && sig_up && !direct;
	assign tear    = link_ok && !sig_up && direct;

	assign v_ext = SW'(vc_rd);
	assign c_ext = SW'(cost_rd);
	assign v_sat = (v_ext > SW'(COST_MAX)) ? COST_MAX : COST_BITS'(v_ext);

	assign w1_match  = valid_q[ix] && (9'(nh_rd) != 9'(ix)) && (nh_rd == peer_q);
	assign w1_raise  = c_ext < v_ext;
	assign w2_ok     = seen_q[ix] && (9'(ix) != 9'(own_q)) && (vc_rd < limit_q);
	assign w2_better = c_ext > v_ext;

	assign c_inc     = DW'(cost_rd) + DW'(1);
	assign dump_cost = (c_inc > DW'({OUT_COST_BITS{1'b1}})) ?
		{OUT_COST_BITS{1'b1}} : OUT_COST_BITS'(c_inc);

	assign out_free  = !m_tvalid || m_tready;
	assign dump_take = (cmd.act == ACT_DUMP) && valid_q[ix] && (!pend_v_q || out_free);

	assign sts.out_free = out_free;
	assign sts.tear     = tear;
	assign sts.direct   = direct;
	assign sts.hit      = valid_q[ix];
	assign sts.pend_v   = pend_v_q;

	// memory writes
	always_comb begin
		nh_we   = 1'b0;
		cost_we = 1'b0;
		wa      = ix;
		cost_wd = v_sat;
		case (cmd.act)
			ACT_LINK: begin
				nh_we   = install;
				cost_we = install;
				wa      = peer_ix;
				cost_wd = COST_ONE;
			end
			ACT_W1: begin
				cost_we = w1_match && seen_q[ix] && w1_raise;
			end
			ACT_W2: begin
				nh_we   = w2_ok && (!valid_q[ix] || w2_better);
				cost_we = nh_we;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (nh_we)
			nh_mem[wa] <= peer_q;
		if (cost_we)
			cost_mem[wa] <= cost_wd;
		if (cmd.act == ACT_ACCEPT && op_t'(s_tuser) == OP_VEC && in_rng)
			vc_mem[in_ix] <= s_tdata[31:16];
		nh_rd   <= nh_mem[raddr];
		cost_rd <= cost_mem[raddr];
		vc_rd   <= vc_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q   <= '0;
			thr_q   <= SIG_THR_RESET;
			limit_q <= COST_LIMIT_RESET;
			ren_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OWN_ID:     own_q   <= cfg_data[ID_BITS-1:0];
				REG_SIG_THR:    thr_q   <= cfg_data[SIG_BITS-1:0];
				REG_COST_LIMIT: limit_q <= cfg_data[ADV_BITS-1:0];
				REG_ROUTE_EN:   ren_q   <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			seen_q   <= '0;
			pend_v_q <= 1'b0;
		end else begin
			case (cmd.act)
				ACT_ACCEPT: begin
					pend_v_q <= 1'b0;
					if (op_t'(s_tuser) == OP_VEC && in_rng)
						seen_q[in_ix] <= 1'b1;
				end
				ACT_LINK: begin
					if (install)
						valid_q[peer_ix] <= 1'b1;
					else if (tear)
						valid_q[peer_ix] <= 1'b0;
				end
				ACT_TEAR: begin
					if (valid_q[ix] && nh_rd == peer_q)
						valid_q[ix] <= 1'b0;
				end
				ACT_W1: begin
					if (w1_match && !seen_q[ix])
						valid_q[ix] <= 1'b0;
				end
				ACT_W2: begin
					if (w2_ok)
						valid_q[ix] <= 1'b1;
				end
				ACT_VCLR: seen_q <= '0;
				ACT_DUMP: begin
					if (dump_take)
						pend_v_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// item fields and result flags
	always_ff @(posedge clk) begin
		case (cmd.act)
			ACT_ACCEPT: begin
				op_q   <= op_t'(s_tuser);
				peer_q <= s_tdata[3:0];
				sig_q  <= s_tdata[11:4];
				dest_q <= in_dest;
				mod_q  <= 1'b0;
				newc_q <= 1'b0;
				newr_q <= 1'b0;
				hop_q  <= '0;
				hv_q   <= 1'b0;
			end
			ACT_LINK: begin
				if (install) begin
					mod_q  <= 1'b1;
					newc_q <= 1'b1;
					newr_q <= !valid_q[peer_ix];
				end else if (tear) begin
					mod_q <= 1'b1;
				end
			end
			ACT_W1: begin
				if (w1_match && (!seen_q[ix] || w1_raise))
					mod_q <= 1'b1;
			end
			ACT_W2: begin
				if (w2_ok && (!valid_q[ix] || w2_better))
					mod_q <= 1'b1;
				if (w2_ok && !valid_q[ix])
					newr_q <= 1'b1;
			end
			ACT_QUERY: begin
				if (!ren_q) begin
					hop_q <= dest_q;
					hv_q  <= 1'b1;
				end else if (dest_rng && valid_q[dest_ix]) begin
					hop_q <= nh_rd;
					hv_q  <= 1'b1;
				end
			end
			ACT_DUMP: begin
				if (dump_take) begin
					pend_d_q    <= ID_BITS'(ix);
					pend_cost_q <= dump_cost;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_comb begin
		ld_out  = 1'b0;
		ld_last = 1'b0;
		ld_data = '0;
		case (cmd.act)
			ACT_EMIT: begin
				ld_out  = out_free;
				ld_data = {24'd0, hv_q, hop_q, newr_q, newc_q, mod_q};
			end
			ACT_DUMP: begin
				ld_out  = dump_take && pend_v_q;
				ld_data = {3'd0, 1'b1, pend_cost_q, pend_d_q, 8'd0};
			end
			ACT_FIN: begin
				ld_out  = out_free;
				ld_last = 1'b1;
				ld_data = pend_v_q ? {3'd0, 1'b1, pend_cost_q, pend_d_q, 8'd0} : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (ld_out)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			m_tdata <= ld_data;
			m_tuser <= (cmd.act == ACT_EMIT) ? op_q : OP_DUMP;
			m_tlast <= ld_last;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |-> (!m_tvalid || m_tready))
		else $error("result register loaded while holding an untaken item");
	a_seen_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act == ACT_VCLR) |=> (seen_q == '0))
		else $error("vector buffer not cleared");
	a_last_on_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_out && ld_last) |-> (cmd.act == ACT_FIN))
		else $error("last flag loaded outside the end of a dump");
`endif

endmodule

// ----- hw/rtl/dvrt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Sequencer for link reports, vector walks, queries and dumps.
// ----------------------------------------------------------------------------
module dvrt_ctrl #(
	parameter int unsigned NODES = dvrt_pkg::NODES_DEF,
	parameter int unsigned IW    = $clog2(NODES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [1:0]          s_tuser,
	input  logic                s_tlast,
	input  dvrt_pkg::dvrt_sts_t sts,
	output dvrt_pkg::dvrt_cmd_t cmd,
	output logic [IW-1:0]       ix,
	output logic [IW-1:0]       walk_addr
);
	import dvrt_pkg::*;

	state_t              state_q, state_n;
	logic [IW-1:0]       d_q, d_n;
	logic [CNT_BITS-1:0] cnt_q, cnt_n;
	logic                d_last, adv;
	logic [CNT_BITS:0]   emitted;

	assign d_last  = d_q == IW'(NODES - 1);
	assign ix      = d_q;
	assign emitted = (CNT_BITS + 1)'(cnt_q) + (CNT_BITS + 1)'(sts.pend_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			d_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			d_q     <= d_n;
			cnt_q   <= cnt_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		d_n       = d_q;
		cnt_n     = cnt_q;
		s_tready  = 1'b0;
		cmd.act   = ACT_NONE;
		cmd.rsel  = RS_WALK;
		adv       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.act = ACT_ACCEPT;
					d_n     = '0;
					cnt_n   = '0;
					unique case (op_t'(s_tuser))
						OP_LINK:  state_n = ST_LINK_RD;
						OP_VEC:   state_n = s_tlast ? ST_VEC_RD : ST_IDLE;
						OP_QUERY: state_n = ST_QRY_RD;
						OP_DUMP:  state_n = ST_DUMP_RD;
					endcase
				end
			end
			ST_LINK_RD: begin
				cmd.rsel = RS_PEER;
				state_n  = ST_LINK_EX;
			end
			ST_LINK_EX: begin
				cmd.act = ACT_LINK;
				d_n     = '0;
				state_n = sts.tear ? ST_TEAR_RD : ST_EMIT;
			end
			ST_TEAR_RD: state_n = ST_TEAR_EX;
			ST_TEAR_EX: begin
				cmd.act = ACT_TEAR;
				adv     = 1'b1;
				d_n     = d_q + IW'(1);
				if (d_last)
					state_n = ST_EMIT;
			end
			ST_VEC_RD: begin
				cmd.rsel = RS_PEER;
				state_n  = ST_VEC_CHK;
			end
			ST_VEC_CHK: begin
				d_n     = '0;
				state_n = sts.direct ? ST_W1_RD : ST_VCLR;
			end
			ST_W1_RD: state_n = ST_W1_EX;
			ST_W1_EX: begin
				cmd.act = ACT_W1;
				adv     = 1'b1;
				d_n     = d_q + IW'(1);
				if (d_last)
					state_n = ST_W2_RD;
			end
			ST_W2_RD: state_n = ST_W2_EX;
			ST_W2_EX: begin
				cmd.act = ACT_W2;
				adv     = 1'b1;
				d_n     = d_q + IW'(1);
				if (d_last)
					state_n = ST_VCLR;
			end
			ST_VCLR: begin
				cmd.act = ACT_VCLR;
				state_n = ST_EMIT;
			end
			ST_QRY_RD: begin
				cmd.rsel = RS_DEST;
				state_n  = ST_QRY_EX;
			end
			ST_QRY_EX: begin
				cmd.act = ACT_QUERY;
				state_n = ST_EMIT;
			end
			ST_DUMP_RD: state_n = ST_DUMP_EX;
			ST_DUMP_EX: begin
				cmd.act = ACT_DUMP;
				adv     = !(sts.hit && sts.pend_v && !sts.out_free);
				if (adv) begin
					if (sts.hit && sts.pend_v)
						cnt_n = cnt_q + CNT_BITS'(1);
					if ((sts.hit && emitted == (CNT_BITS + 1)'(MAX_RESULTS - 1)) || d_last)
						state_n = ST_FIN;
					else
						d_n = d_q + IW'(1);
				end
			end
			ST_FIN: begin
				cmd.act = ACT_FIN;
				if (sts.out_free)
					state_n = ST_IDLE;
			end
			ST_EMIT: begin
				cmd.act = ACT_EMIT;
				if (sts.out_free)
					state_n = ST_IDLE;
			end
		endcase
		walk_addr = adv ? d_q + IW'(1) : d_q;
	end

`ifndef SYNTHESIS
	a_dump_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP_EX && sts.hit && sts.pend_v && !sts.out_free)
		|=> (state_q == ST_DUMP_EX && $stable(d_q)))
		else $error("dump walk moved while the result register was full");
	a_w1_to_w2: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_W1_EX && d_last) |=> (state_q == ST_W2_RD && d_q == '0))
		else $error("second vector walk did not start from entry zero");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == ST_IDLE))
		else $error("input ready outside the idle state");
`endif

endmodule

// ----- hw/rtl/distance_vector_route_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Route table with link reports, distance-vector merge, query and dump.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ stream; s_tuser carries the operation (link report,
//   vector entry, next hop query, dump) and s_tlast closes a distance vector.
//   Results leave on the m_ stream; m_tuser carries the result kind and
//   m_tlast marks the last entry of a dump run.
//   Vector entries that are not last are buffered and give no result.
//   Link report: the peer entry is read and updated; when a link is torn
//   down, a table walk then drops every route through that peer.
//   Query: the destination entry is read. Vector end: the peer entry is read
//   and, when the peer is a direct neighbour, two table walks follow, one
//   entry per cycle through the registered read port of the route memories.
//   Dump: a table walk, one entry per cycle while the receiver keeps up.
//   One item is worked on at a time; s_tready is high only between items.
//   A finished result sits in the output register, so the next item is taken
//   while it waits; when the receiver stalls, the walk or final step holds
//   until the register frees.
//   Reset clears the valid bits and the vector buffer at once and loads the
//   register defaults; no clearing pass is needed. Configuration writes go
//   through cfg_we/cfg_index/cfg_data and take effect on the next cycle.
// ----------------------------------------------------------------------------
module distance_vector_route_table #(
	parameter int unsigned NODES     = dvrt_pkg::NODES_DEF,
	parameter int unsigned COST_BITS = dvrt_pkg::COST_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side: tdata = peer[3:0], signal_dbm[11:4], dest[15:12], adv_cost[31:16]
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dvrt_pkg::IN_BITS-1:0]  s_tdata,
	// tuser = op
	input  logic [1:0]                    s_tuser,
	input  logic                          s_tlast,
	// master side: tdata = modified[0], new_connected[1], new_reachable[2],
	// hop[6:3], hop_valid[7], out_dest[11:8], out_cost[27:12], entry_valid[28]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dvrt_pkg::OUT_BITS-1:0] m_tdata,
	// tuser = kind
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [dvrt_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [dvrt_pkg::CFG_BITS-1:0] cfg_data
);
	import dvrt_pkg::*;

	localparam int unsigned IW = $clog2(NODES);

	dvrt_cmd_t     cmd;
	dvrt_sts_t     sts;
	logic [IW-1:0] ix;
	logic [IW-1:0] walk_addr;

	// sequencer: decodes the item, steps the table walks, paces the results
	dvrt_ctrl #(
		.NODES (NODES),
		.IW    (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.sts       (sts),
		.cmd       (cmd),
		.ix        (ix),
		.walk_addr (walk_addr)
	);

	// storage and arithmetic: route memories, vector buffer, result register
	dvrt_datapath #(
		.NODES     (NODES),
		.COST_BITS (COST_BITS),
		.IW        (IW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ix        (ix),
		.walk_addr (walk_addr),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
